// ----- rtl/ufm_pkg.sv -----
// Shared types and constants of the UTF-8 substring matcher.
package ufm_pkg;

  // Fixed field widths
  localparam int TEXT_W    = 8;
  localparam int NEEDLE_W  = 64;
  localparam int LEN_W     = 4;
  localparam int ORD_W     = 32;
  localparam int PRIOR_W   = 3;
  localparam int CFG_IDX_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN   = 4'd1;

  // UTF-8 continuation bytes have the form 10xxxxxx
  localparam logic [TEXT_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [TEXT_W-1:0] CONT_TAG  = 8'h80;

  // Largest reportable ordinal
  localparam logic [ORD_W-1:0] ORD_MAX = 32'hFFFF_FFFF;

  // Outcome of the window compare for the current byte
  typedef struct packed {
    logic               hit;
    logic [PRIOR_W-1:0] prior_leads;
  } cmp_res_t;

  // True for any byte that starts a character
  function automatic logic is_lead(input logic [TEXT_W-1:0] b);
    return (b & CONT_MASK) != CONT_TAG;
  endfunction

endpackage

// ----- rtl/ufm_in_if.sv -----
// Text byte channel carrying one byte and its last-byte flag per item.
interface ufm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ufm_pkg::TEXT_W-1:0] text_byte;
  logic                       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- rtl/ufm_out_if.sv -----
// Result channel carrying one match or completion report per item.
interface ufm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      match_found;
  logic [ufm_pkg::ORD_W-1:0] match_ordinal;
  logic                      text_done;

  modport source (output valid, output match_found, output match_ordinal,
                  output text_done, input ready);
  modport sink   (input valid, input match_found, input match_ordinal,
                  input text_done, output ready);
endinterface

// ----- rtl/ufm_cfg_if.sv -----
// Configuration write channel carrying a register index and write data.
interface ufm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ufm_pkg::CFG_IDX_W-1:0] reg_index;
  logic [ufm_pkg::NEEDLE_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/ufm_window_cmp.sv -----
// Parallel compare of the byte window against the needle for every length.
module ufm_window_cmp #(
  parameter int MAX_NEEDLE = 8
) (
  input  logic [ufm_pkg::TEXT_W-1:0]   cur_byte,
  input  logic [ufm_pkg::TEXT_W-1:0]   win_bytes [((MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1)],
  input  logic                         win_leads [((MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1)],
  input  logic [ufm_pkg::NEEDLE_W-1:0] needle,
  input  logic [ufm_pkg::LEN_W-1:0]    len_eff,
  output ufm_pkg::cmp_res_t            res
);

  logic                        hit_l   [MAX_NEEDLE];
  logic [ufm_pkg::PRIOR_W-1:0] prior_l [MAX_NEEDLE];

  // One candidate per needle length: the needle ends at the current byte and
  // its earlier bytes sit in the window, most recent first.
  always_comb begin
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      hit_l[l-1]   = (needle[(l-1)*ufm_pkg::TEXT_W +: ufm_pkg::TEXT_W] == cur_byte);
      prior_l[l-1] = '0;
      for (int j = 0; j + 1 < l; j++) begin
        if (win_bytes[l-2-j] != needle[j*ufm_pkg::TEXT_W +: ufm_pkg::TEXT_W]) begin
          hit_l[l-1] = 1'b0;
        end
        prior_l[l-1] = prior_l[l-1] + ufm_pkg::PRIOR_W'(win_leads[l-2-j]);
      end
    end
  end

  // Pick the candidate for the needle length in use; zero length never hits.
  always_comb begin
    res = '0;
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      if (len_eff == ufm_pkg::LEN_W'(l)) begin
        res.hit         = hit_l[l-1];
        res.prior_leads = prior_l[l-1];
      end
    end
  end

endmodule

// ----- rtl/utf8_findall_matcher.sv -----
// Top level of the streaming non-overlapping UTF-8 substring matcher.
//
//  Channel  | Dir | Payload                                     | Accepted when
//  ---------+-----+---------------------------------------------+-------------------
//  in_if    | in  | text_byte[7:0], last_byte                   | valid && ready
//  out_if   | out | match_found, match_ordinal[31:0], text_done | valid && ready
//  cfg_if   | in  | reg_index[3:0], wdata[63:0]                 | valid && ready
//
// One item per cycle sustained while results are not stalled. An accepted item
// sits in the input register; when the input stage advances, the combinational
// window compare loads the result register, which offers the result.
// Reset (rst_n low, synchronous) clears the needle, window and counters.
// A stalled result holds the input stage only while a result is waiting.
// Configuration writes are always ready.
module utf8_findall_matcher #(
  parameter int MAX_NEEDLE = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ufm_in_if.sink    in_if,
  ufm_out_if.source out_if,
  ufm_cfg_if.sink   cfg_if
);

  localparam int WIN_DEPTH = MAX_NEEDLE - 1;
  localparam int WIN_D     = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int OW        = (COUNT_BITS + 1 > ufm_pkg::ORD_W + 1) ? COUNT_BITS + 1
                                                                  : ufm_pkg::ORD_W + 1;

  // Configuration registers
  logic [ufm_pkg::NEEDLE_W-1:0] needle_r;
  logic [ufm_pkg::LEN_W-1:0]    needle_len_r;
  logic [ufm_pkg::LEN_W-1:0]    len_eff;

  // Input stage
  logic                       in_valid_r;
  logic [ufm_pkg::TEXT_W-1:0] byte_r;
  logic                       last_r;
  logic                       advance;

  // Text state
  logic [ufm_pkg::TEXT_W-1:0] win_bytes_r [WIN_D];
  logic                       win_leads_r [WIN_D];
  logic [ufm_pkg::LEN_W-1:0]  fill_r, fill_nxt;
  logic [COUNT_BITS-1:0]      lead_r, lead_nxt;
  logic [ufm_pkg::LEN_W-1:0]  skip_r, skip_nxt;

  // Result stage
  logic                      out_valid_r;
  logic                      found_r;
  logic [ufm_pkg::ORD_W-1:0] ord_r;
  logic                      done_r;

  ufm_pkg::cmp_res_t         cmp_res;
  logic                      cur_lead;
  logic                      found;
  logic [COUNT_BITS-1:0]     prior_ext;
  logic [COUNT_BITS-1:0]     base_leads;
  logic [OW-1:0]             ord_ext;
  logic [ufm_pkg::ORD_W-1:0] ordinal;

  // Configuration writes; unknown indexes are ignored.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r     <= '0;
      needle_len_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        ufm_pkg::REG_NEEDLE_BYTES: needle_r     <= cfg_if.wdata;
        ufm_pkg::REG_NEEDLE_LEN:   needle_len_r <= cfg_if.wdata[ufm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the window capacity behave as the maximum length.
  assign len_eff = (needle_len_r > ufm_pkg::LEN_W'(MAX_NEEDLE)) ? ufm_pkg::LEN_W'(MAX_NEEDLE)
                                                              : needle_len_r;

  // The input stage moves on whenever the result register is free or emptying.
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      byte_r <= in_if.text_byte;
      last_r <= in_if.last_byte;
    end
  end

  ufm_window_cmp #(
    .MAX_NEEDLE(MAX_NEEDLE)
  ) u_cmp (
    .cur_byte (byte_r),
    .win_bytes(win_bytes_r),
    .win_leads(win_leads_r),
    .needle   (needle_r),
    .len_eff  (len_eff),
    .res      (cmp_res)
  );

  // Match decision, suppression and counter updates for the held byte.
  always_comb begin
    cur_lead = ufm_pkg::is_lead(byte_r);
    found    = 1'b0;
    skip_nxt = skip_r;
    if (skip_r != '0) begin
      skip_nxt = skip_r - 1'b1;
    end else if (len_eff != '0 && fill_r >= len_eff - 1'b1 && cmp_res.hit) begin
      found    = 1'b1;
      skip_nxt = len_eff - 1'b1;
    end
    fill_nxt = (fill_r < ufm_pkg::LEN_W'(WIN_DEPTH)) ? fill_r + 1'b1 : fill_r;
    lead_nxt = (cur_lead && lead_r != '1) ? lead_r + 1'b1 : lead_r;
    if (last_r) begin
      skip_nxt = '0;
      fill_nxt = '0;
      lead_nxt = '0;
    end
  end

  // Ordinal of the match start, saturating at the all-ones value.
  always_comb begin
    prior_ext  = COUNT_BITS'(cmp_res.prior_leads);
    base_leads = (lead_r >= prior_ext) ? lead_r - prior_ext : '0;
    ord_ext    = OW'(base_leads) + OW'(1);
    if (lead_r == '1 || ord_ext > OW'(ufm_pkg::ORD_MAX)) begin
      ordinal = ufm_pkg::ORD_MAX;
    end else begin
      ordinal = ord_ext[ufm_pkg::ORD_W-1:0];
    end
  end

  // Text state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lead_r <= '0;
      skip_r <= '0;
    end else if (advance) begin
      fill_r <= fill_nxt;
      lead_r <= lead_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Byte window, most recent byte in entry 0; cleared after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_D; k++) begin
        win_bytes_r[k] <= '0;
        win_leads_r[k] <= 1'b0;
      end
    end else if (advance) begin
      if (last_r || WIN_DEPTH == 0) begin
        for (int k = 0; k < WIN_D; k++) begin
          win_bytes_r[k] <= '0;
          win_leads_r[k] <= 1'b0;
        end
      end else begin
        for (int k = WIN_D - 1; k > 0; k--) begin
          win_bytes_r[k] <= win_bytes_r[k-1];
          win_leads_r[k] <= win_leads_r[k-1];
        end
        win_bytes_r[0] <= byte_r;
        win_leads_r[0] <= cur_lead;
      end
    end
  end

  // Result register: an item gives a result on a match or on its last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= found || last_r;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      found_r <= found;
      ord_r   <= found ? ordinal : '0;
      done_r  <= last_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.match_found   = found_r;
  assign out_if.match_ordinal = ord_r;
  assign out_if.text_done     = done_r;

endmodule
